// ----- rtl/mva_pkg.sv -----
// Shared types and constants for the MIDI voice allocator.
// No dependencies; every other file imports this package.
package mva_pkg;

	localparam int KEY_COUNT       = 128;
	localparam int KEY_W           = 7;
	localparam int SLOT_KEY_W      = 8;
	localparam int VOICE_COUNT_DEF = 8;

	localparam logic [SLOT_KEY_W-1:0] NO_KEY = 8'd128;

	localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
	localparam logic [3:0] NIB_NOTE_ON  = 4'h9;
	localparam logic [3:0] NIB_CONTROL  = 4'hB;

	localparam logic [1:0] EV_NONE    = 2'd0;
	localparam logic [1:0] EV_START   = 2'd1;
	localparam logic [1:0] EV_RELEASE = 2'd2;
	localparam logic [1:0] EV_CONTROL = 2'd3;

	typedef enum logic [1:0] {
		OP_NOP,
		OP_START,
		OP_RELEASE,
		OP_CTRL
	} op_t;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	typedef struct packed {
		logic [7:0]       status_byte;
		logic [KEY_W-1:0] data_one;
		logic [KEY_W-1:0] data_two;
	} msg_t;

	typedef struct packed {
		logic [1:0]       event_kind;
		logic [2:0]       voice_index;
		logic [KEY_W-1:0] note_key;
		logic [KEY_W-1:0] note_velocity;
		logic [7:0]       release_mask;
		logic [KEY_W-1:0] control_number;
		logic [KEY_W-1:0] control_value;
	} evt_t;

	typedef struct packed {
		logic             en;
		logic [KEY_W-1:0] addr;
		logic             data;
	} km_wr_t;

	typedef struct packed {
		logic             start;
		logic             release_key;
		logic [KEY_W-1:0] key;
		logic [KEY_W-1:0] vel;
	} vb_cmd_t;

endpackage

// ----- rtl/mva_keymap.sv -----
// Pressed-key map: 128 x 1 synchronous memory with registered read.
// Runs a clearing sweep after reset. Depends on mva_pkg.
module mva_keymap import mva_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [KEY_W-1:0] rd_addr,
	output logic             rd_data,
	input  km_wr_t           wr,
	output logic             ready
);

	logic             mem [KEY_COUNT];
	logic             rd_data_q;
	logic             clearing_q;
	logic [KEY_W-1:0] clr_q;
	logic             we;
	logic [KEY_W-1:0] waddr;
	logic             wdata;

	assign ready   = !clearing_q;
	assign rd_data = rd_data_q;

	always_comb begin
		if (clearing_q) begin
			we    = 1'b1;
			waddr = clr_q;
			wdata = 1'b0;
		end else begin
			we    = wr.en;
			waddr = wr.addr;
			wdata = wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
		end else if (clearing_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == KEY_W'(KEY_COUNT - 1))
				clearing_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (rd_en)
			rd_data_q <= mem[rd_addr];
	end

endmodule

// ----- rtl/mva_voice_bank.sv -----
// Voice slots (key, level), rotating scan pointer, free-voice search
// and release match. Depends on mva_pkg.
module mva_voice_bank import mva_pkg::*; #(
	parameter  int VOICE_COUNT = VOICE_COUNT_DEF,
	localparam int IDX_W       = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  vb_cmd_t                cmd,
	output logic                   free_found,
	output logic [IDX_W-1:0]       free_idx,
	output logic [VOICE_COUNT-1:0] match_mask
);

	logic [SLOT_KEY_W-1:0] key_q   [VOICE_COUNT];
	logic [KEY_W-1:0]      level_q [VOICE_COUNT];
	logic [IDX_W-1:0]      ptr_q;

	logic [VOICE_COUNT-1:0] free_vec;
	logic [VOICE_COUNT-1:0] upper_vec;
	logic                   found_hi;
	logic [IDX_W-1:0]       idx_hi;
	logic [IDX_W-1:0]       idx_lo;

	always_comb begin
		for (int v = 0; v < VOICE_COUNT; v++) begin
			free_vec[v]   = (level_q[v] == '0);
			upper_vec[v]  = free_vec[v] && (IDX_W'(v) >= ptr_q);
			match_mask[v] = (key_q[v] == {1'b0, cmd.key});
		end
	end

	// Rotating priority: lowest free voice at or above the pointer, else lowest overall.
	always_comb begin
		found_hi = 1'b0;
		idx_hi   = '0;
		idx_lo   = '0;
		for (int v = VOICE_COUNT - 1; v >= 0; v--) begin
			if (upper_vec[v]) begin
				found_hi = 1'b1;
				idx_hi   = IDX_W'(v);
			end
			if (free_vec[v])
				idx_lo = IDX_W'(v);
		end
		free_found = |free_vec;
		free_idx   = found_hi ? idx_hi : idx_lo;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int v = 0; v < VOICE_COUNT; v++) begin
				key_q[v]   <= NO_KEY;
				level_q[v] <= '0;
			end
			ptr_q <= '0;
		end else begin
			if (cmd.release_key) begin
				for (int v = 0; v < VOICE_COUNT; v++) begin
					if (match_mask[v])
						level_q[v] <= '0;
				end
			end
			// No free voice leaves the pointer where it was after a full turn.
			if (cmd.start && free_found) begin
				key_q[free_idx]   <= {1'b0, cmd.key};
				level_q[free_idx] <= cmd.vel;
				if (free_idx == IDX_W'(VOICE_COUNT - 1))
					ptr_q <= '0;
				else
					ptr_q <= free_idx + 1'b1;
			end
		end
	end

endmodule

// ----- rtl/midi_voice_allocator_top.sv -----
// Channel    Direction  Payload  Handshake
// msg        in         msg_t    msg_valid / msg_stall
// evt        out        evt_t    evt_valid / evt_stall
//
// Accepting a message in ST_IDLE reads the pressed-key memory; ST_EXEC then
// updates the key map and voice slots and loads the result register.
// After reset the key map is swept clear over all 128 keys with msg_stall high.
// A result held by evt_stall delays the update cycle; the next message is
// taken only after the current one has been written into the result register.
// Top level of the MIDI voice allocator. Depends on mva_pkg, mva_keymap,
// mva_voice_bank.
module midi_voice_allocator_top import mva_pkg::*; #(
	parameter int VOICE_COUNT = VOICE_COUNT_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic msg_valid,
	output logic msg_stall,
	input  msg_t msg,
	output logic evt_valid,
	input  logic evt_stall,
	output evt_t evt
);

	localparam int IDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;

	state_t state_q, state_d;
	logic   km_ready;
	logic   key_down;
	logic   accept;
	logic   fire;
	op_t    op_d;

	op_t              op_s1;
	logic [KEY_W-1:0] key_s1;
	logic [KEY_W-1:0] vel_s1;

	logic                   free_found;
	logic [IDX_W-1:0]       free_idx;
	logic [VOICE_COUNT-1:0] match_mask;
	vb_cmd_t                vb_cmd;
	km_wr_t                 km_wr;

	logic out_valid_q;
	evt_t out_q;
	evt_t res;

	assign msg_stall = !km_ready || (state_q != ST_IDLE);
	assign accept    = msg_valid && !msg_stall;
	assign fire      = (state_q == ST_EXEC) && (!out_valid_q || !evt_stall);
	assign evt_valid = out_valid_q;
	assign evt       = out_q;

	always_comb begin
		case (msg.status_byte[7:4])
			NIB_NOTE_OFF: op_d = OP_RELEASE;
			NIB_NOTE_ON:  op_d = (msg.data_two == '0) ? OP_RELEASE : OP_START;
			NIB_CONTROL:  op_d = OP_CTRL;
			default:      op_d = OP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept)
					state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (fire)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1  <= op_d;
			key_s1 <= msg.data_one;
			vel_s1 <= msg.data_two;
		end
	end

	mva_keymap u_keymap (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (msg.data_one),
		.rd_data (key_down),
		.wr      (km_wr),
		.ready   (km_ready)
	);

	always_comb begin
		km_wr.en   = fire && (((op_s1 == OP_START) && !key_down) ||
		                      ((op_s1 == OP_RELEASE) && key_down));
		km_wr.addr = key_s1;
		km_wr.data = (op_s1 == OP_START);

		vb_cmd.start       = fire && (op_s1 == OP_START) && !key_down;
		vb_cmd.release_key = fire && (op_s1 == OP_RELEASE) && key_down;
		vb_cmd.key         = key_s1;
		vb_cmd.vel         = vel_s1;
	end

	mva_voice_bank #(
		.VOICE_COUNT (VOICE_COUNT)
	) u_voice_bank (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (vb_cmd),
		.free_found (free_found),
		.free_idx   (free_idx),
		.match_mask (match_mask)
	);

	always_comb begin
		res = '0;
		case (op_s1)
			OP_START: begin
				if (!key_down && free_found) begin
					res.event_kind    = EV_START;
					res.voice_index   = 3'(free_idx);
					res.note_key      = key_s1;
					res.note_velocity = vel_s1;
				end
			end
			OP_RELEASE: begin
				if (key_down) begin
					res.event_kind   = EV_RELEASE;
					res.note_key     = key_s1;
					res.release_mask = 8'(match_mask);
				end
			end
			OP_CTRL: begin
				res.event_kind     = EV_CONTROL;
				res.control_number = key_s1;
				res.control_value  = vel_s1;
			end
			default: res.event_kind = EV_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (fire)
			out_valid_q <= 1'b1;
		else if (!evt_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (fire)
			out_q <= res;
	end

endmodule

// ----- rtl/mva_checker.sv -----
// Port-level checks for the MIDI voice allocator, bound to the top level.
// Depends on mva_pkg and midi_voice_allocator_top.
module mva_checker import mva_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic msg_valid,
	input logic msg_stall,
	input msg_t msg,
	input logic evt_valid,
	input logic evt_stall,
	input evt_t evt
);

	// One message in flight: the cycle after a transaction the input is held off.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(msg_valid && !msg_stall) |=> msg_stall)
		else $error("message accepted while previous one still in flight");

	a_none_is_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(evt_valid && evt.event_kind == EV_NONE) |->
		(evt.voice_index == '0 && evt.note_key == '0 && evt.note_velocity == '0 &&
		 evt.release_mask == '0 && evt.control_number == '0 && evt.control_value == '0))
		else $error("empty result carries nonzero fields");

	a_start_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(evt_valid && evt.event_kind == EV_START) |->
		(evt.note_velocity != '0 && evt.release_mask == '0 && evt.control_number == '0))
		else $error("voice start result malformed");

	a_evt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(evt_valid && evt_stall) |=> (evt_valid && $stable(evt)))
		else $error("stalled result changed");

endmodule

bind midi_voice_allocator_top mva_checker u_mva_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.msg_valid (msg_valid),
	.msg_stall (msg_stall),
	.msg       (msg),
	.evt_valid (evt_valid),
	.evt_stall (evt_stall),
	.evt       (evt)
);
